@@ rtl/fpcr_pkg.sv @@
// Package for the fractal plane coordinate remap: payload structs, plane codes
// and the reciprocal-plane test. Depends on nothing.
`timescale 1ns / 1ps
package fpcr_pkg;

  typedef struct packed {
    logic signed [31:0] re_in;
    logic signed [31:0] im_in;
  } fpcr_in_t;

  typedef struct packed {
    logic signed [31:0] re_out;
    logic signed [31:0] im_out;
    logic               overflow_flag;
  } fpcr_out_t;

  typedef enum logic [2:0] {
    PLANE_IDENT    = 3'd0,
    PLANE_RECIP    = 3'd1,
    PLANE_RECIP_Q  = 3'd2,
    PLANE_LAMBDA   = 3'd3,
    PLANE_LAM_INV  = 3'd4,
    PLANE_LAM_INV1 = 3'd5,
    PLANE_RECIP_C  = 3'd6,
    PLANE_SPARE    = 3'd7
  } plane_t;

  // Stage A register of fpcr_post: operands (reciprocal or raw) for the products.
  typedef struct packed {
    logic               vld;
    plane_t             mode;
    logic               guard;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } stage_t;

  // Reciprocal-based planes.
  function automatic logic is_recip(input plane_t m);
    is_recip = (m == PLANE_RECIP) || (m == PLANE_RECIP_Q) || (m == PLANE_LAM_INV) ||
               (m == PLANE_LAM_INV1) || (m == PLANE_RECIP_C);
  endfunction

endpackage

@@ rtl/fpcr_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, one item per cycle
// while adv is high. Depends on fpcr_pkg. Computes min(floor(n*2^(2F)/d), cap) for two numerators.
`timescale 1ns / 1ps
module fpcr_div
  import fpcr_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int QB        = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  plane_t            in_mode,
  input  logic              in_guard,
  input  logic              in_sx,
  input  logic              in_sy,
  input  logic [31:0]       in_ax,
  input  logic [31:0]       in_ay,
  input  logic [63:0]       in_d,
  output logic              out_vld,
  output plane_t            out_mode,
  output logic              out_guard,
  output logic              out_sx,
  output logic              out_sy,
  output logic [QB-1:0]     out_qx,
  output logic [QB-1:0]     out_qy
);
  // Quotient bits beyond QB only matter as "too big": divide by shifted form.
  localparam int NB = 32 + 2 * FRAC_BITS;  // numerator bits
  localparam int ST = QB;                  // one stage per kept quotient bit

  // Since quotient is capped below 2^QB, fold numerator bits above position
  // QB-1 into a big-flag check: q >= 2^QB iff n*2^2F >= d*2^QB.
  logic            v_r   [ST+1];
  plane_t          m_r   [ST+1];
  logic            g_r   [ST+1];
  logic            sx_r  [ST+1];
  logic            sy_r  [ST+1];
  logic [63:0]     d_r   [ST+1];
  logic [NB+1:0]   rx_r  [ST+1];  // partial remainder, numerator aligned
  logic [NB+1:0]   ry_r  [ST+1];
  logic [QB-1:0]   qx_r  [ST+1];
  logic [QB-1:0]   qy_r  [ST+1];
  logic            bx_r  [ST+1];  // quotient already at cap
  logic            by_r  [ST+1];

  // Stage 0: register inputs; check overflow of the top (NB-QB) quotient bits.
  logic [127:0] nx_w, ny_w, dsh_w;
  always_comb begin
    nx_w  = {96'd0, in_ax} << (2 * FRAC_BITS);
    ny_w  = {96'd0, in_ay} << (2 * FRAC_BITS);
    dsh_w = {64'd0, in_d} << QB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_vld;
    end
    if (adv) begin
      m_r[0]  <= in_mode;
      g_r[0]  <= in_guard;
      sx_r[0] <= in_sx;
      sy_r[0] <= in_sy;
      d_r[0]  <= in_d;
      rx_r[0] <= nx_w[NB+1:0];
      ry_r[0] <= ny_w[NB+1:0];
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      bx_r[0] <= (nx_w >= dsh_w);
      by_r[0] <= (ny_w >= dsh_w);
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_stage
    localparam int SH = QB - 1 - s;
    logic [127:0] tx_w, ty_w, ds_w;
    always_comb begin
      ds_w = {64'd0, d_r[s]} << SH;
      tx_w = {{(126 - NB){1'b0}}, rx_r[s]};
      ty_w = {{(126 - NB){1'b0}}, ry_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (adv) begin
        v_r[s+1] <= v_r[s];
      end
      if (adv) begin
        m_r[s+1]  <= m_r[s];
        g_r[s+1]  <= g_r[s];
        sx_r[s+1] <= sx_r[s];
        sy_r[s+1] <= sy_r[s];
        d_r[s+1]  <= d_r[s];
        bx_r[s+1] <= bx_r[s];
        by_r[s+1] <= by_r[s];
        if (tx_w >= ds_w) begin
          rx_r[s+1] <= (NB+2)'(tx_w - ds_w);
          qx_r[s+1] <= qx_r[s] | (QB'(1) << SH);
        end else begin
          rx_r[s+1] <= rx_r[s];
          qx_r[s+1] <= qx_r[s];
        end
        if (ty_w >= ds_w) begin
          ry_r[s+1] <= (NB+2)'(ty_w - ds_w);
          qy_r[s+1] <= qy_r[s] | (QB'(1) << SH);
        end else begin
          ry_r[s+1] <= ry_r[s];
          qy_r[s+1] <= qy_r[s];
        end
      end
    end
  end

  assign out_vld   = v_r[ST];
  assign out_mode  = m_r[ST];
  assign out_guard = g_r[ST];
  assign out_sx    = sx_r[ST];
  assign out_sy    = sy_r[ST];
  assign out_qx    = bx_r[ST] ? {QB{1'b1}} : qx_r[ST];
  assign out_qy    = by_r[ST] ? {QB{1'b1}} : qy_r[ST];
endmodule

@@ rtl/fpcr_post.sv @@
// Post stages: signed reciprocal, offsets, lambda map, saturation; three
// register stages. Depends on fpcr_pkg.
`timescale 1ns / 1ps
module fpcr_post
  import fpcr_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int EB        = 32,
  parameter int QB        = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  plane_t          in_mode,
  input  logic            in_guard,
  input  logic            in_sx,
  input  logic            in_sy,
  input  logic [QB-1:0]   in_qx,
  input  logic [QB-1:0]   in_qy,
  input  logic [31:0]     in_rx,
  input  logic [31:0]     in_ry,
  output logic            out_vld,
  output fpcr_out_t       out_data
);
  localparam logic signed [63:0] WMAX = (64'sd1 <<< (EB - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
  localparam logic signed [63:0] ONE_RAW = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] QTR_RAW = 64'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [63:0] C14_RAW =
    64'((140115 * (64'd1 << FRAC_BITS) + 50000) / 100000);

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             inout logic f);
    if (v > WMAX) begin
      f = 1'b1;
      sat = WMAX;
    end else if (v < WMIN) begin
      f = 1'b1;
      sat = WMIN;
    end else begin
      sat = v;
    end
  endfunction

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

  // Stage A: select operands (reciprocal or raw), apply offsets.
  stage_t a_r;
  logic   fa_r;
  logic   lam_a_r;
  stage_t a_nxt;
  logic   fa_nxt, lam_nxt;
  always_comb begin : p_a
    logic signed [63:0] qx, qy, rr, ri, x, y;
    logic f;
    f  = 1'b0;
    qx = {{(64 - QB){1'b0}}, in_qx};
    qy = {{(64 - QB){1'b0}}, in_qy};
    x  = sx32(in_rx);
    y  = sx32(in_ry);
    rr = x;
    ri = y;
    if (is_recip(in_mode)) begin
      if (in_guard) begin
        rr = WMAX;
        ri = WMAX;
        f  = 1'b1;
      end else begin
        rr = sat(in_sx ? -qx : qx, f);
        ri = sat(in_sy ? qy : -qy, f);
        case (in_mode)
          PLANE_RECIP_Q:  rr = sat(rr + QTR_RAW, f);
          PLANE_RECIP_C:  rr = sat(rr - C14_RAW, f);
          PLANE_LAM_INV1: rr = sat(rr + ONE_RAW, f);
          default:        rr = rr;
        endcase
      end
    end else begin
      rr = sat(x, f);
      ri = sat(y, f);
    end
    a_nxt.vld   = in_vld;
    a_nxt.mode  = in_mode;
    a_nxt.guard = in_guard;
    a_nxt.a     = rr;
    a_nxt.b     = ri;
    fa_nxt      = f;
    lam_nxt     = (in_mode == PLANE_LAMBDA) ||
                  (!in_guard && ((in_mode == PLANE_LAM_INV) ||
                                 (in_mode == PLANE_LAM_INV1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else if (adv) begin
      a_r.vld <= a_nxt.vld;
    end
    if (adv) begin
      a_r.mode  <= a_nxt.mode;
      a_r.guard <= a_nxt.guard;
      a_r.a     <= a_nxt.a;
      a_r.b     <= a_nxt.b;
      fa_r      <= fa_nxt;
      lam_a_r   <= lam_nxt;
    end
  end

  // Stage B: signed products (operands fit in 32 bits after saturation).
  logic               vb_r, fb_r, lam_b_r;
  logic signed [63:0] xb_r, yb_r, xx_r, yy_r, xy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= a_r.vld;
    end
    if (adv) begin
      fb_r    <= fa_r;
      lam_b_r <= lam_a_r;
      xb_r    <= a_r.a;
      yb_r    <= a_r.b;
      xx_r    <= $signed(a_r.a[31:0]) * $signed(a_r.a[31:0]);
      yy_r    <= $signed(a_r.b[31:0]) * $signed(a_r.b[31:0]);
      xy_r    <= $signed(a_r.a[31:0]) * $signed(a_r.b[31:0]);
    end
  end

  // Stage C: lambda combine and final saturation. Arithmetic >>> is floor.
  fpcr_out_t o_nxt;
  always_comb begin : p_c
    logic signed [63:0] sq, rr, ri;
    logic f;
    f  = fb_r;
    sq = $signed(xx_r) - $signed(yy_r);
    rr = xb_r;
    ri = yb_r;
    if (lam_b_r) begin
      rr = sat((xb_r >>> 1) - (sq >>> (FRAC_BITS + 2)), f);
      ri = sat((yb_r >>> 1) - (xy_r >>> (FRAC_BITS + 1)), f);
    end
    o_nxt.re_out        = rr[31:0];
    o_nxt.im_out        = ri[31:0];
    o_nxt.overflow_flag = f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vb_r;
    end
    if (adv) begin
      out_data <= o_nxt;
    end
  end
endmodule

@@ rtl/fractal_plane_coordinate_remap.sv @@
// Top level of the fractal plane coordinate remap; instantiates fpcr_div and
// fpcr_post. Depends on fpcr_pkg.
//
// Usage:
//  - Input channel in_valid/in_stall carries one coordinate (fpcr_in_t);
//    a transfer happens when in_valid is high and in_stall low.
//  - Result channel out_valid/out_stall carries re_out, im_out and the
//    overflow flag; one result per accepted coordinate, in order.
//  - cfg_we/cfg_wdata writes plane_mode; write it only while idle.
//  - From the input transfer to out_valid, a coordinate passes the entry
//    register (loaded at the transfer edge), one magnitude stage, the
//    divider's input stage, QB quotient-bit stages (one bit per stage) and
//    three output stages.
//  - Throughput is one coordinate per cycle while no result waits on a
//    stalled receiver; the divider chain sets the depth but not the rate.
//  - The whole pipeline moves as one: when out_stall is high and a result
//    waits, every stage holds and in_stall rises. in_stall equals
//    out_valid && out_stall, so nothing is dropped or repeated.
//  - Synchronous active-low reset clears all valid bits and plane_mode.
`timescale 1ns / 1ps
module fractal_plane_coordinate_remap
  import fpcr_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fpcr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output fpcr_out_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_wdata
);
  localparam int EB = (WORD_BITS > 32) ? 32 : WORD_BITS;
  localparam int QB = EB + 1;
  localparam logic [32:0] EPS_RAW =
    33'(((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000);

  logic   adv;
  plane_t mode_r;

  // Advance the whole pipe unless a result is waiting on a stalled receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PLANE_IDENT;
    end else if (cfg_we) begin
      mode_r <= plane_t'(cfg_wdata);
    end
  end

  // Entry stage: register the coordinate and tag it with the mode.
  logic            v0_r;
  plane_t          m0_r;
  logic [31:0]     x0_r, y0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
    if (adv) begin
      m0_r <= mode_r;
      x0_r <= in_data.re_in;
      y0_r <= in_data.im_in;
    end
  end

  // Magnitude stage: |x|, |y|, guard test, and the squared norm.
  logic [31:0] ax_w, ay_w;
  always_comb begin
    ax_w = x0_r[31] ? (32'd0 - x0_r) : x0_r;
    ay_w = y0_r[31] ? (32'd0 - y0_r) : y0_r;
  end

  logic        v1_r, g1_r, sx1_r, sy1_r;
  plane_t      m1_r;
  logic [31:0] ax1_r, ay1_r, x1_r, y1_r;
  logic [63:0] d1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      m1_r  <= m0_r;
      g1_r  <= ({1'b0, ax_w} + {1'b0, ay_w}) < EPS_RAW;
      sx1_r <= x0_r[31];
      sy1_r <= y0_r[31];
      ax1_r <= ax_w;
      ay1_r <= ay_w;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      d1_r  <= 64'(ax_w) * 64'(ax_w) + 64'(ay_w) * 64'(ay_w);
    end
  end

  // Raw coordinate delayed alongside the divider for the non-reciprocal planes.
  logic [31:0] xd_r [QB+1];
  logic [31:0] yd_r [QB+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      xd_r[0] <= x1_r;
      yd_r[0] <= y1_r;
      for (int i = 0; i < QB; i++) begin
        xd_r[i+1] <= xd_r[i];
        yd_r[i+1] <= yd_r[i];
      end
    end
  end

  // A zero norm only occurs under the guard; feed 1 to keep the divider sane.
  logic [63:0] dsafe_w;
  assign dsafe_w = (d1_r == 64'd0) ? 64'd1 : d1_r;

  logic          dv_w, dg_w, dsx_w, dsy_w;
  plane_t        dm_w;
  logic [QB-1:0] qx_w, qy_w;

  fpcr_div #(.FRAC_BITS(FRAC_BITS), .QB(QB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (v1_r),
    .in_mode   (m1_r),
    .in_guard  (g1_r),
    .in_sx     (sx1_r),
    .in_sy     (sy1_r),
    .in_ax     (ax1_r),
    .in_ay     (ay1_r),
    .in_d      (dsafe_w),
    .out_vld   (dv_w),
    .out_mode  (dm_w),
    .out_guard (dg_w),
    .out_sx    (dsx_w),
    .out_sy    (dsy_w),
    .out_qx    (qx_w),
    .out_qy    (qy_w)
  );

  fpcr_post #(.FRAC_BITS(FRAC_BITS), .EB(EB), .QB(QB)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (dv_w),
    .in_mode  (dm_w),
    .in_guard (dg_w),
    .in_sx    (dsx_w),
    .in_sy    (dsy_w),
    .in_qx    (qx_w),
    .in_qy    (qy_w),
    .in_rx    (xd_r[QB]),
    .in_ry    (yd_r[QB]),
    .out_vld  (out_valid),
    .out_data (out_data)
  );
endmodule

@@ rtl/fpcr_checker.sv @@
// Port-level checker for fractal_plane_coordinate_remap, bound to the top
// level. Depends on fpcr_pkg.
`timescale 1ns / 1ps
module fpcr_checker
  import fpcr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input fpcr_out_t out_data
);
  a_stall_only_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("input stalled without cause");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  a_stall_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input open while a result waits");
endmodule

bind fractal_plane_coordinate_remap fpcr_checker u_fpcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ test/tb_fractal_plane_coordinate_remap.sv @@
// Self-checking bench for fractal_plane_coordinate_remap: random and directed
// coordinates through every plane mode, checked against an in-bench predictor.
// Depends on fpcr_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_fractal_plane_coordinate_remap;
  import fpcr_pkg::*;

  localparam int FRAC = 24;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd1 << FRAC;
  localparam longint QUARTER_Q = 64'sd1 << (FRAC - 2);
  // 1.40115 rounded to the nearest raw step
  localparam longint C14_Q = (140115 * (64'sd1 << FRAC) + 50000) / 100000;
  // 1e-6 rounded up to raw units
  localparam longint NEAR_ZERO_Q = ((64'sd1 << FRAC) + 999999) / 1000000;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  logic [2:0] cfg_wdata;
  fpcr_in_t in_data;
  fpcr_out_t out_data;

  fractal_plane_coordinate_remap u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  fpcr_in_t pending_coords[$];
  fpcr_out_t expected_points[$];
  plane_t plane_sel;
  int mismatches;
  int idle_cycles;
  bit in_took;
  bit out_took;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 32-bit word; flag any clamp.
  function automatic longint clamp_word(input longint v, inout bit f);
    if (v > WMAX) begin
      f = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      f = 1;
      return WMIN;
    end
    return v;
  endfunction

  // Floor division by 2^s.
  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  // floor(a * 2^(2F) / d), capped at 2^32.
  function automatic longint recip_quot(input longint a, input logic [63:0] d);
    logic [127:0] num, q;
    num = 128'(a) << (2 * FRAC);
    q = num / 128'(d);
    if (q > 128'(64'sd1 << 32)) return 64'sd1 << 32;
    return longint'(q[63:0]);
  endfunction

  function automatic void lambda_step(input longint x, input longint y,
                                      output longint rr, output longint ri,
                                      inout bit f);
    longint sq, xy;
    sq = x * x - y * y;
    xy = x * y;
    rr = clamp_word(floor_shift(x, 1) - floor_shift(sq, FRAC + 2), f);
    ri = clamp_word(floor_shift(y, 1) - floor_shift(xy, FRAC + 1), f);
  endfunction

  function automatic fpcr_out_t remap_point(input plane_t m, input fpcr_in_t c);
    fpcr_out_t r;
    longint x, y, rr, ri, ax, ay, qr, qi;
    logic [63:0] d;
    bit f;
    x = c.re_in;
    y = c.im_in;
    rr = x;
    ri = y;
    f = 0;
    if (is_recip(m)) begin
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      if (ax + ay < NEAR_ZERO_Q) begin
        rr = WMAX;
        ri = WMAX;
        f = 1;
      end else begin
        d = ax * ax + ay * ay;
        qr = recip_quot(ax, d);
        qi = recip_quot(ay, d);
        rr = clamp_word(x < 0 ? -qr : qr, f);
        ri = clamp_word(y < 0 ? qi : -qi, f);
        case (m)
          PLANE_RECIP_Q: rr = clamp_word(rr + QUARTER_Q, f);
          PLANE_RECIP_C: rr = clamp_word(rr - C14_Q, f);
          PLANE_LAM_INV: lambda_step(rr, ri, rr, ri, f);
          PLANE_LAM_INV1: lambda_step(clamp_word(rr + ONE_Q, f), ri, rr, ri, f);
          default: ;
        endcase
      end
    end else if (m == PLANE_LAMBDA) begin
      lambda_step(x, y, rr, ri, f);
    end
    r.re_out = rr[31:0];
    r.im_out = ri[31:0];
    r.overflow_flag = f;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Driver: pop the next coordinate after a random gap, hold it until transfer.
  int in_gap;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        expected_points.push_back(remap_point(plane_sel, in_data));
        void'(pending_coords.pop_front());
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 7) == 0) in_gap = 0;
      end
      if (in_valid && !in_took) begin
        // hold the stalled transfer
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 0;
      end else if (pending_coords.size() > 0) begin
        in_valid <= 1;
        in_data <= pending_coords[0];
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Result stall: a random number of stalled cycles before each transfer,
  // with stretches where the receiver never stalls.
  int out_hold;
  bit out_burst;
  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      out_hold = out_burst ? 0 : $urandom_range(0, 15);
    end
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // Monitor: record both handshakes and compare each result transfer against
  // the oldest expectation.
  always @(posedge clk) begin
    in_took = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
      if (out_took) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result re", out_data.re_out, 0);
        end else begin
          fpcr_out_t e;
          e = expected_points[0];
          if (out_data.re_out !== e.re_out)
            report_mismatch("re_out", out_data.re_out, e.re_out);
          if (out_data.im_out !== e.im_out)
            report_mismatch("im_out", out_data.im_out, e.im_out);
          if (out_data.overflow_flag !== e.overflow_flag)
            report_mismatch("overflow_flag", out_data.overflow_flag, e.overflow_flag);
          void'(expected_points.pop_front());
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fractal_plane_coordinate_remap: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 64)) - 32);
      2: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      default: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
    endcase
  endfunction

  task automatic add_coord(input logic [31:0] re, input logic [31:0] im);
    fpcr_in_t c;
    c.re_in = re;
    c.im_in = im;
    pending_coords.push_back(c);
  endtask

  // Wait until every expectation is met and the pipeline has emptied, then
  // write the plane mode.
  task automatic set_plane(input plane_t m);
    while (pending_coords.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 0;
    plane_sel = m;
  endtask

  task automatic directed_set();
    add_coord(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_coord(32'h80000000, 32'h80000000);
    add_coord(32'h7FFFFFFF, 32'h80000000);
    add_coord(0, 0);
    add_coord(32'd16, 0);
    add_coord(32'd17, 0);
    add_coord(32'hFFFFFFF8, 32'd8);
    add_coord(32'(ONE_Q), 0);
    add_coord(0, 32'(-ONE_Q));
    add_coord(32'(ONE_Q), 32'(ONE_Q));
    add_coord(1, 32'd15);
    add_coord(32'h00000100, 0);
    add_coord(32'hFFFFFFFF, 32'hFFFFFFFF);
  endtask

  initial begin
    plane_t modes[$];
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_wdata = PLANE_IDENT;
    plane_sel = PLANE_IDENT;
    mismatches = 0;
    idle_cycles = 0;
    in_gap = 0;
    out_hold = 0;
    out_burst = 0;
    in_took = 0;
    out_took = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // Reset mode is identity: exercise it before any write.
    directed_set();
    modes = '{PLANE_RECIP, PLANE_RECIP_Q, PLANE_LAMBDA, PLANE_LAM_INV,
              PLANE_LAM_INV1, PLANE_RECIP_C, PLANE_SPARE, PLANE_IDENT};
    foreach (modes[i]) begin
      set_plane(modes[i]);
      directed_set();
    end
    // Random phases across all modes, 1035 coordinates in total.
    for (int ph = 0; ph < 23; ph++) begin
      set_plane(plane_t'(ph < 8 ? ph : $urandom_range(0, 7)));
      for (int k = 0; k < 45; k++) add_coord(rand_word(), rand_word());
    end
    while (pending_coords.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("fractal_plane_coordinate_remap: match");
    else $display("fractal_plane_coordinate_remap: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/fpcr_pkg.sv
rtl/fpcr_div.sv
rtl/fpcr_post.sv
rtl/fractal_plane_coordinate_remap.sv
rtl/fpcr_checker.sv
test/tb_fractal_plane_coordinate_remap.sv
